// ===== hw/rtl/arh_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// arh_pkg
// Shared constants, codes and controller/datapath interface types for the
// auto-ranging histogram.
// ----------------------------------------------------------------------------
package arh_pkg;

  localparam int BIN_CAPACITY = 1024;
  localparam int SLOT_W       = $clog2(BIN_CAPACITY);
  localparam int CLR_W        = $clog2(BIN_CAPACITY + 1);
  localparam int COUNT_WIDTH  = 32;

  localparam int DATA_W    = 32;  // sample and range registers
  localparam int WIDTH_W   = 31;  // bin width register
  localparam int BIN_W     = 34;  // window edges, wide enough never to wrap
  localparam int QUO_W     = DATA_W + 1;
  localparam int DIV_STEPS = DATA_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  localparam int CFG_IDX_W = 2;
  localparam int POS_W     = 10;
  localparam int WBINS_W   = 11;
  localparam int EXT_W     = 2;
  localparam int OUT_W     = 32;

  localparam logic [WIDTH_W-1:0] RST_BIN_WIDTH = WIDTH_W'(65536);
  localparam logic [DATA_W-1:0]  RST_RANGE_MIN = DATA_W'(0);
  localparam logic [DATA_W-1:0]  RST_RANGE_MAX = DATA_W'(16711680);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BIN_WIDTH = 2'd0,
    REG_RANGE_MIN = 2'd1,
    REG_RANGE_MAX = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    CMD_ADD  = 1'b0,
    CMD_READ = 1'b1
  } command_e;

  typedef enum logic [EXT_W-1:0] {
    EXT_NONE  = 2'd0,
    EXT_ABOVE = 2'd1,
    EXT_BELOW = 2'd2
  } ext_e;

  typedef enum logic [1:0] {
    SRC_SAMPLE = 2'd0,
    SRC_MIN    = 2'd1,
    SRC_MAX    = 2'd2
  } div_src_e;

  typedef enum logic [1:0] {
    CLR_ALL   = 2'd0,
    CLR_ABOVE = 2'd1,
    CLR_BELOW = 2'd2
  } clr_kind_e;

  typedef enum logic [1:0] {
    WR_CLEAR = 2'd0,
    WR_ONE   = 2'd1,
    WR_INC   = 2'd2
  } wr_kind_e;

  typedef enum logic [2:0] {
    OUT_INSIDE   = 3'd0,
    OUT_EXT      = 3'd1,
    OUT_EXT_REJ  = 3'd2,
    OUT_READ     = 3'd3,
    OUT_READ_REJ = 3'd4
  } out_kind_e;

  typedef struct packed {
    logic      take_item;
    logic      div_start;
    div_src_e  div_src;
    logic      set_low;
    logic      set_high;
    logic      fix_high;
    logic      clear_total;
    logic      latch_bin;
    logic      clr_load;
    clr_kind_e clr_kind;
    logic      mem_read;
    logic      mem_write;
    wr_kind_e  wr_kind;
    logic      bump_total;
    logic      ext_commit;
    logic      out_load;
    out_kind_e out_kind;
  } arh_cmd_t;

  typedef struct packed {
    logic cfg_wr;
    logic div_done;
    logic item_read;
    logic in_window;
    logic ext_above;
    logic ext_reject;
    logic rd_in_window;
    logic clr_done;
    logic out_free;
  } arh_status_t;

  // stored count shown on the 32-bit result, saturated
  function automatic logic [OUT_W-1:0] count_to_out(input logic [COUNT_WIDTH-1:0] c);
    logic [63:0] w;
    w = 64'(c);
    if (w > 64'(32'hFFFF_FFFF)) return '1;
    return w[OUT_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/auto_ranging_histogram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// auto_ranging_histogram
// Histogram of signed Q16.16 samples over a window of bins that grows to
// take in samples outside it, up to the bin store's capacity.
// ----------------------------------------------------------------------------
// One item at a time; a read skips the divider. An add finds the sample's
// bin with the bit-serial divider (32 steps). When the window is extended,
// each newly covered bin (at most BIN_CAPACITY-1) is written in turn, since
// the count memory has a single write port. After reset and after each write
// to a defined register the block divides both range registers and clears
// all BIN_CAPACITY slots (1024) of the store; no item is taken until that
// ends, though register writes still are. A finished result waits in an
// output register while the next item is taken in.
module auto_ranging_histogram (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [arh_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [arh_pkg::DATA_W-1:0]        cfg_data,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic                              command,
  input  wire logic signed [arh_pkg::DATA_W-1:0] sample,
  input  wire logic [arh_pkg::POS_W-1:0]         read_index,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [arh_pkg::POS_W-1:0]              bin_position,
  output logic [arh_pkg::OUT_W-1:0]              bin_count,
  output logic [arh_pkg::OUT_W-1:0]              total_entries,
  output logic [arh_pkg::WBINS_W-1:0]            window_bins,
  output logic [arh_pkg::EXT_W-1:0]              extension,
  output logic                                   rejected
);
  import arh_pkg::*;

  arh_cmd_t    cmd;
  arh_status_t status;

  assign cfg_ready = 1'b1;

  arh_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  arh_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .command       (command),
    .sample        (sample),
    .read_index    (read_index),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .bin_position  (bin_position),
    .bin_count     (bin_count),
    .total_entries (total_entries),
    .window_bins   (window_bins),
    .extension     (extension),
    .rejected      (rejected)
  );

endmodule
`default_nettype wire

// ===== hw/rtl/arh_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// arh_div
// Restoring divider, one quotient bit per cycle, giving floor(dividend/divisor)
// for a signed dividend and an unsigned divisor (zero treated as one).
// ----------------------------------------------------------------------------
module arh_div (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  input  wire logic signed [arh_pkg::DATA_W-1:0] dividend,
  input  wire logic [arh_pkg::WIDTH_W-1:0]       divisor,
  output logic                                   done,
  output logic signed [arh_pkg::QUO_W-1:0]       quotient
);
  import arh_pkg::*;

  logic                 busy;
  logic                 fin;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 neg;
  logic [DATA_W-1:0]    mag;   // dividend magnitude, becomes quotient
  logic [DATA_W-1:0]    rem;
  logic [WIDTH_W-1:0]   dvs;
  logic [DATA_W:0]      trial;
  logic [DATA_W:0]      diff;
  logic [QUO_W-1:0]     qmag;

  assign trial = {rem, mag[DATA_W-1]};
  assign diff  = trial - {2'b00, dvs};
  assign qmag  = {1'b0, mag};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        fin  <= 1'b0;
        cnt  <= DIV_CNT_W'(DIV_STEPS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end else if (fin) begin
        fin  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[DATA_W-1];
      mag <= dividend[DATA_W-1] ? DATA_W'(-dividend) : DATA_W'(dividend);
      rem <= '0;
      dvs <= (divisor == '0) ? WIDTH_W'(1) : divisor;
    end else if (busy) begin
      if (!diff[DATA_W]) begin
        rem <= diff[DATA_W-1:0];
        mag <= {mag[DATA_W-2:0], 1'b1};
      end else begin
        rem <= trial[DATA_W-1:0];
        mag <= {mag[DATA_W-2:0], 1'b0};
      end
    end else if (fin) begin
      // floor for negatives: -q when exact, -q-1 otherwise
      quotient <= neg ? (~qmag + QUO_W'(rem == '0)) : qmag;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/arh_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// arh_dp
// Histogram datapath: configuration registers, divider, window edges, count
// memory with its clearing pointer, totals and the result register.
// ----------------------------------------------------------------------------
module arh_dp (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire arh_pkg::arh_cmd_t                   cmd,
  output arh_pkg::arh_status_t                     status,
  input  wire logic                                cfg_valid,
  input  wire logic [arh_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [arh_pkg::DATA_W-1:0]          cfg_data,
  input  wire logic                                command,
  input  wire logic signed [arh_pkg::DATA_W-1:0]   sample,
  input  wire logic [arh_pkg::POS_W-1:0]           read_index,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [arh_pkg::POS_W-1:0]                bin_position,
  output logic [arh_pkg::OUT_W-1:0]                bin_count,
  output logic [arh_pkg::OUT_W-1:0]                total_entries,
  output logic [arh_pkg::WBINS_W-1:0]              window_bins,
  output logic [arh_pkg::EXT_W-1:0]                extension,
  output logic                                     rejected
);
  import arh_pkg::*;

  localparam logic signed [BIN_W-1:0]  CAP_S     = BIN_W'(BIN_CAPACITY);
  localparam logic [COUNT_WIDTH-1:0]   COUNT_MAX = '1;

  // configuration
  logic [WIDTH_W-1:0]       bin_width;
  logic signed [DATA_W-1:0] range_min;
  logic signed [DATA_W-1:0] range_max;

  // latched item
  logic                     item_cmd;
  logic signed [DATA_W-1:0] item_sample;
  logic [POS_W-1:0]         item_index;

  // window and bin
  logic signed [BIN_W-1:0] low_bin;
  logic signed [BIN_W-1:0] high_bin;
  logic signed [BIN_W-1:0] bin;
  logic [OUT_W-1:0]        total;
  logic                    ext_up;

  // clearing pointer
  logic [SLOT_W-1:0] clr_ptr;
  logic [CLR_W-1:0]  clr_cnt;

  // divider
  logic signed [DATA_W-1:0] div_in;
  logic                     div_done;
  logic signed [QUO_W-1:0]  quo;
  logic signed [BIN_W-1:0]  quo_x;

  // memory
  logic [COUNT_WIDTH-1:0] mem [BIN_CAPACITY];
  logic [COUNT_WIDTH-1:0] rd_data;
  logic [SLOT_W-1:0]      rd_addr;
  logic [SLOT_W-1:0]      wr_addr;
  logic [COUNT_WIDTH-1:0] wr_data;
  logic [COUNT_WIDTH-1:0] inc_val;

  logic signed [BIN_W-1:0] b_minus_low;
  logic signed [BIN_W-1:0] high_minus_b;
  logic signed [BIN_W-1:0] b_minus_high;
  logic signed [BIN_W-1:0] low_minus_b1;
  logic signed [BIN_W-1:0] win;
  logic signed [BIN_W-1:0] fix_diff;
  logic                    cfg_hit;
  logic                    above;

  always_comb begin
    case (cfg_index)
      REG_BIN_WIDTH, REG_RANGE_MIN, REG_RANGE_MAX: cfg_hit = 1'b1;
      default:                                     cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_width <= RST_BIN_WIDTH;
      range_min <= RST_RANGE_MIN;
      range_max <= RST_RANGE_MAX;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_BIN_WIDTH: bin_width <= cfg_data[WIDTH_W-1:0];
        REG_RANGE_MIN: range_min <= cfg_data;
        REG_RANGE_MAX: range_max <= cfg_data;
        default:       ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_item) begin
      item_cmd    <= command;
      item_sample <= sample;
      item_index  <= read_index;
    end
  end

  always_comb begin
    case (cmd.div_src)
      SRC_MIN: div_in = range_min;
      SRC_MAX: div_in = range_max;
      default: div_in = item_sample;
    endcase
  end

  arh_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_in),
    .divisor  (bin_width),
    .done     (div_done),
    .quotient (quo)
  );

  assign quo_x = {quo[QUO_W-1], quo};

  assign b_minus_low  = bin - low_bin;
  assign high_minus_b = high_bin - bin;
  assign b_minus_high = bin - high_bin;
  assign low_minus_b1 = low_bin - bin - BIN_W'(1);
  assign win          = high_bin - low_bin;
  assign fix_diff     = high_bin - low_bin;
  assign above        = (bin >= high_bin);

  always_ff @(posedge clk) begin
    if (cmd.set_low) low_bin <= quo_x;
    else if (cmd.ext_commit && !ext_up) low_bin <= bin;

    if (cmd.set_high) high_bin <= quo_x + BIN_W'(1);
    else if (cmd.fix_high) begin
      // empty/inverted window gets one bin; over-wide window is cut to capacity
      if (fix_diff <= BIN_W'(0))  high_bin <= low_bin + BIN_W'(1);
      else if (fix_diff > CAP_S)  high_bin <= low_bin + CAP_S;
    end else if (cmd.ext_commit && ext_up) high_bin <= bin + BIN_W'(1);

    if (cmd.latch_bin) bin <= quo_x;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total <= '0;
    end else if (cmd.clear_total) begin
      total <= '0;
    end else if (cmd.bump_total && total != '1) begin
      total <= total + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr_load) begin
      case (cmd.clr_kind)
        CLR_ABOVE: clr_cnt <= b_minus_high[CLR_W-1:0];
        CLR_BELOW: clr_cnt <= low_minus_b1[CLR_W-1:0];
        default:   clr_cnt <= CLR_W'(BIN_CAPACITY);
      endcase
    end else if (cmd.mem_write && cmd.wr_kind == WR_CLEAR) begin
      clr_cnt <= clr_cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_load) begin
      case (cmd.clr_kind)
        CLR_ABOVE: begin
          clr_ptr <= high_bin[SLOT_W-1:0];
          ext_up  <= 1'b1;
        end
        CLR_BELOW: begin
          clr_ptr <= bin[SLOT_W-1:0] + 1'b1;
          ext_up  <= 1'b0;
        end
        default: clr_ptr <= '0;
      endcase
    end else if (cmd.mem_write && cmd.wr_kind == WR_CLEAR) begin
      clr_ptr <= clr_ptr + 1'b1;
    end
  end

  // slots are the low bits of the absolute bin (two's complement modulo)
  assign rd_addr = (item_cmd == CMD_READ) ? low_bin[SLOT_W-1:0] + SLOT_W'(item_index)
                                          : bin[SLOT_W-1:0];
  assign inc_val = (rd_data == COUNT_MAX) ? rd_data : rd_data + 1'b1;

  always_comb begin
    case (cmd.wr_kind)
      WR_ONE: begin
        wr_addr = bin[SLOT_W-1:0];
        wr_data = COUNT_WIDTH'(1);
      end
      WR_INC: begin
        wr_addr = bin[SLOT_W-1:0];
        wr_data = inc_val;
      end
      default: begin
        wr_addr = clr_ptr;
        wr_data = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_write) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_read) rd_data <= mem[rd_addr];
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      total_entries <= total;
      window_bins   <= win[WBINS_W-1:0];
      case (cmd.out_kind)
        OUT_INSIDE: begin
          bin_position <= b_minus_low[POS_W-1:0];
          bin_count    <= count_to_out(inc_val);
          extension    <= EXT_NONE;
          rejected     <= 1'b0;
        end
        OUT_EXT: begin
          bin_position <= ext_up ? b_minus_low[POS_W-1:0] : '0;
          bin_count    <= OUT_W'(1);
          extension    <= ext_up ? EXT_ABOVE : EXT_BELOW;
          rejected     <= 1'b0;
        end
        OUT_READ: begin
          bin_position <= item_index;
          bin_count    <= count_to_out(rd_data);
          extension    <= EXT_NONE;
          rejected     <= 1'b0;
        end
        OUT_READ_REJ: begin
          bin_position <= item_index;
          bin_count    <= '0;
          extension    <= EXT_NONE;
          rejected     <= 1'b1;
        end
        default: begin
          bin_position <= '0;
          bin_count    <= '0;
          extension    <= EXT_NONE;
          rejected     <= 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    status.cfg_wr       = cfg_valid && cfg_hit;
    status.div_done     = div_done;
    status.item_read    = (item_cmd == CMD_READ);
    status.in_window    = (bin >= low_bin) && (bin < high_bin);
    status.ext_above    = above;
    status.ext_reject   = above ? (b_minus_low >= CAP_S) : (high_minus_b > CAP_S);
    status.rd_in_window = ({1'b0, item_index} < win[WBINS_W-1:0]);
    status.clr_done     = (clr_cnt == '0);
    status.out_free     = !out_valid || !out_stall;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/arh_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// arh_ctrl
// Sequencer for the histogram: window reload and clearing pass, add and read
// commands, extension clearing and result hand-off.
// ----------------------------------------------------------------------------
module arh_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire arh_pkg::arh_status_t status,
  output arh_pkg::arh_cmd_t         cmd
);
  import arh_pkg::*;

  typedef enum logic [14:0] {
    S_RL_MIN   = 15'b000000000000001,
    S_RL_MIN_W = 15'b000000000000010,
    S_RL_MAX   = 15'b000000000000100,
    S_RL_MAX_W = 15'b000000000001000,
    S_RL_FIX   = 15'b000000000010000,
    S_RL_CLR   = 15'b000000000100000,
    S_IDLE     = 15'b000000001000000,
    S_ADD_DIV  = 15'b000000010000000,
    S_ADD_W    = 15'b000000100000000,
    S_ADD_CLS  = 15'b000001000000000,
    S_ADD_INC  = 15'b000010000000000,
    S_EXT_CLR  = 15'b000100000000000,
    S_EXT_SET  = 15'b001000000000000,
    S_RD_CHK   = 15'b010000000000000,
    S_OUT      = 15'b100000000000000
  } state_t;

  state_t    state;
  state_t    state_next;
  out_kind_e kind;
  out_kind_e kind_next;

  assign in_stall = (state != S_IDLE) || status.cfg_wr;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_RL_MIN;
      kind  <= OUT_INSIDE;
    end else begin
      state <= state_next;
      kind  <= kind_next;
    end
  end

  always_comb begin
    state_next = state;
    kind_next  = kind;
    cmd        = '0;
    cmd.out_kind = kind;

    case (state)
      S_RL_MIN: begin
        cmd.div_start = 1'b1;
        cmd.div_src   = SRC_MIN;
        state_next    = S_RL_MIN_W;
      end
      S_RL_MIN_W: begin
        if (status.div_done) begin
          cmd.set_low = 1'b1;
          state_next  = S_RL_MAX;
        end
      end
      S_RL_MAX: begin
        cmd.div_start = 1'b1;
        cmd.div_src   = SRC_MAX;
        state_next    = S_RL_MAX_W;
      end
      S_RL_MAX_W: begin
        if (status.div_done) begin
          cmd.set_high = 1'b1;
          state_next   = S_RL_FIX;
        end
      end
      S_RL_FIX: begin
        cmd.fix_high    = 1'b1;
        cmd.clear_total = 1'b1;
        cmd.clr_load    = 1'b1;
        cmd.clr_kind    = CLR_ALL;
        state_next      = S_RL_CLR;
      end
      S_RL_CLR: begin
        if (status.clr_done) begin
          state_next = S_IDLE;
        end else begin
          cmd.mem_write = 1'b1;
          cmd.wr_kind   = WR_CLEAR;
        end
      end
      S_IDLE: begin
        if (in_valid && !status.cfg_wr) begin
          cmd.take_item = 1'b1;
          state_next    = S_ADD_DIV;
        end
      end
      S_ADD_DIV: begin
        // item is latched now; reads skip the divider
        if (status.item_read) begin
          state_next = S_RD_CHK;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_src   = SRC_SAMPLE;
          state_next    = S_ADD_W;
        end
      end
      S_ADD_W: begin
        if (status.div_done) begin
          cmd.latch_bin = 1'b1;
          state_next    = S_ADD_CLS;
        end
      end
      S_ADD_CLS: begin
        if (status.in_window) begin
          cmd.mem_read = 1'b1;
          state_next   = S_ADD_INC;
        end else if (status.ext_reject) begin
          kind_next  = OUT_EXT_REJ;
          state_next = S_OUT;
        end else begin
          cmd.clr_load = 1'b1;
          cmd.clr_kind = status.ext_above ? CLR_ABOVE : CLR_BELOW;
          state_next   = S_EXT_CLR;
        end
      end
      S_ADD_INC: begin
        cmd.mem_write  = 1'b1;
        cmd.wr_kind    = WR_INC;
        cmd.bump_total = 1'b1;
        kind_next      = OUT_INSIDE;
        state_next     = S_OUT;
      end
      S_EXT_CLR: begin
        if (status.clr_done) begin
          state_next = S_EXT_SET;
        end else begin
          cmd.mem_write = 1'b1;
          cmd.wr_kind   = WR_CLEAR;
        end
      end
      S_EXT_SET: begin
        cmd.mem_write  = 1'b1;
        cmd.wr_kind    = WR_ONE;
        cmd.ext_commit = 1'b1;
        cmd.bump_total = 1'b1;
        kind_next      = OUT_EXT;
        state_next     = S_OUT;
      end
      S_RD_CHK: begin
        if (status.rd_in_window) begin
          cmd.mem_read = 1'b1;
          kind_next    = OUT_READ;
        end else begin
          kind_next = OUT_READ_REJ;
        end
        state_next = S_OUT;
      end
      S_OUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_RL_MIN;
    endcase

    // any write to a defined register reloads the window and clears the store
    if (status.cfg_wr) begin
      cmd        = '0;
      kind_next  = kind;
      state_next = S_RL_MIN;
    end
  end

endmodule
`default_nettype wire

// ===== tb/tb_auto_ranging_histogram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tb_auto_ranging_histogram
// Self-checking bench for the auto-ranging histogram. A queue of pending
// transfers (register writes and add/read commands) feeds a clocked driver,
// which predicts each accepted command from its own copy of the window,
// the bin store and the registers. A clocked monitor checks every result
// field against the oldest prediction. Both sides idle in random bursts.
// ----------------------------------------------------------------------------
module tb_auto_ranging_histogram;
  timeunit 1ns;
  timeprecision 1ps;

  import arh_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;  // beyond the register list
  localparam longint S_MAX = 2147483647;
  localparam longint S_MIN = -S_MAX - 1;

  typedef struct {
    bit                   is_cfg;
    bit                   drain;   // hold back until every result is back
    logic [CFG_IDX_W-1:0] idx;
    logic [DATA_W-1:0]    data;
    command_e             cmd;
    logic [DATA_W-1:0]    smp;
    logic [POS_W-1:0]     ridx;
  } job_t;

  typedef struct packed {
    logic [POS_W-1:0]   pos;
    logic [OUT_W-1:0]   count;
    logic [OUT_W-1:0]   total;
    logic [WBINS_W-1:0] wbins;
    ext_e               ext;
    logic               rej;
  } bin_result_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_IDX_W-1:0]      cfg_index = '0;
  logic [DATA_W-1:0]         cfg_data = '0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic                      command = 1'b0;
  logic signed [DATA_W-1:0]  sample = '0;
  logic [POS_W-1:0]          read_index = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [POS_W-1:0]          bin_position;
  logic [OUT_W-1:0]          bin_count;
  logic [OUT_W-1:0]          total_entries;
  logic [WBINS_W-1:0]        window_bins;
  logic [EXT_W-1:0]          extension;
  logic                      rejected;

  auto_ranging_histogram dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .command       (command),
    .sample        (sample),
    .read_index    (read_index),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .bin_position  (bin_position),
    .bin_count     (bin_count),
    .total_entries (total_entries),
    .window_bins   (window_bins),
    .extension     (extension),
    .rejected      (rejected)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predicted block state
  logic [WIDTH_W-1:0] reg_width;
  logic [DATA_W-1:0]  reg_min;
  logic [DATA_W-1:0]  reg_max;
  logic [OUT_W-1:0]   hist_counts [BIN_CAPACITY];
  longint             win_low;
  longint             win_high;
  logic [OUT_W-1:0]   seen_total;

  // register values as planned while the job queue is built
  logic [WIDTH_W-1:0] plan_width;
  logic [DATA_W-1:0]  plan_min;
  logic [DATA_W-1:0]  plan_max;

  job_t        jobs[$];
  bin_result_t awaited_bins[$];
  int          items_in = 0;
  int          results_out = 0;
  int          mismatches = 0;
  int          hold = 0;
  int          stall_left = 0;
  bit          calm = 1'b0;

  function automatic longint bin_of(input longint s, input logic [WIDTH_W-1:0] w);
    longint d;
    longint q;
    d = w;
    if (d == 0) d = 1;
    q = s / d;
    if (s % d != 0 && s < 0) q = q - 1;
    return q;
  endfunction

  function automatic int slot_of(input longint b);
    longint m;
    m = b % BIN_CAPACITY;
    if (m < 0) m = m + BIN_CAPACITY;
    return int'(m);
  endfunction

  function automatic void frame_of(input logic [WIDTH_W-1:0] w,
                                   input logic [DATA_W-1:0] mn, mx,
                                   output longint lo, hi);
    lo = bin_of($signed(mn), w);
    hi = bin_of($signed(mx), w) + 1;
    if (hi <= lo) hi = lo + 1;
    if (hi - lo > BIN_CAPACITY) hi = lo + BIN_CAPACITY;
  endfunction

  function automatic void reframe();
    frame_of(reg_width, reg_min, reg_max, win_low, win_high);
    foreach (hist_counts[i]) hist_counts[i] = '0;
    seen_total = '0;
  endfunction

  function automatic void write_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [DATA_W-1:0] val);
    case (idx)
      REG_BIN_WIDTH: reg_width = val[WIDTH_W-1:0];
      REG_RANGE_MIN: reg_min = val;
      REG_RANGE_MAX: reg_max = val;
      default: return;
    endcase
    reframe();
  endfunction

  function automatic void bump_seen();
    if (seen_total != '1) seen_total = seen_total + 1;
  endfunction

  function automatic bin_result_t histogram_step(input command_e cmd,
                                                 input logic signed [DATA_W-1:0] smp,
                                                 input logic [POS_W-1:0] ridx);
    bin_result_t r;
    longint      b;
    longint      k;
    int          s;
    r.pos   = '0;
    r.count = '0;
    r.ext   = EXT_NONE;
    r.rej   = 1'b0;
    if (cmd == CMD_ADD) begin
      b = bin_of(smp, reg_width);
      if (b >= win_low && b < win_high) begin
        s = slot_of(b);
        if (hist_counts[s] != '1) hist_counts[s] = hist_counts[s] + 1;
        bump_seen();
        r.pos   = POS_W'(b - win_low);
        r.count = hist_counts[s];
      end else if (b >= win_high) begin
        if (b + 1 - win_low > BIN_CAPACITY) begin
          r.rej = 1'b1;
        end else begin
          for (k = win_high; k < b; k++) hist_counts[slot_of(k)] = '0;
          hist_counts[slot_of(b)] = 1;
          win_high = b + 1;
          bump_seen();
          r.pos   = POS_W'(b - win_low);
          r.count = 1;
          r.ext   = EXT_ABOVE;
        end
      end else begin
        if (win_high - b > BIN_CAPACITY) begin
          r.rej = 1'b1;
        end else begin
          for (k = b + 1; k < win_low; k++) hist_counts[slot_of(k)] = '0;
          hist_counts[slot_of(b)] = 1;
          win_low = b;
          bump_seen();
          r.count = 1;
          r.ext   = EXT_BELOW;
        end
      end
    end else begin
      r.pos = ridx;
      k = longint'(ridx);
      if (k < win_high - win_low) r.count = hist_counts[slot_of(win_low + k)];
      else r.rej = 1'b1;
    end
    r.total = seen_total;
    r.wbins = WBINS_W'(win_high - win_low);
    return r;
  endfunction

  task automatic check_field(input string what, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
      mismatches++;
    end
  endtask

  // ---- job queue building ----

  function automatic void push_item(input command_e cmd, input logic [DATA_W-1:0] smp,
                                    input logic [POS_W-1:0] ridx, input bit drain);
    job_t j;
    j.is_cfg = 1'b0;
    j.drain  = drain;
    j.idx    = REG_BIN_WIDTH;
    j.data   = '0;
    j.cmd    = cmd;
    j.smp    = smp;
    j.ridx   = ridx;
    jobs = {jobs, j};
  endfunction

  function automatic void push_add(input logic [DATA_W-1:0] smp, input bit drain = 1'b0);
    push_item(CMD_ADD, smp, POS_W'($urandom), drain);
  endfunction

  function automatic void push_read(input logic [POS_W-1:0] ridx, input bit drain = 1'b0);
    push_item(CMD_READ, $urandom, ridx, drain);
  endfunction

  function automatic void push_reg(input logic [CFG_IDX_W-1:0] idx,
                                   input logic [DATA_W-1:0] val);
    job_t j;
    j.is_cfg = 1'b1;
    j.drain  = 1'b1;
    j.idx    = idx;
    j.data   = val;
    j.cmd    = CMD_ADD;
    j.smp    = '0;
    j.ridx   = '0;
    jobs = {jobs, j};
    case (idx)
      REG_BIN_WIDTH: plan_width = val[WIDTH_W-1:0];
      REG_RANGE_MIN: plan_min = val;
      REG_RANGE_MAX: plan_max = val;
      default: ;
    endcase
  endfunction

  // Samples aimed mostly at or just beside the starting window; now and then
  // far off, so that long extensions and rejects turn up as well.
  function automatic void push_random(input int n);
    longint lo, hi, span, w, b, s, r;
    int     reach;
    frame_of(plan_width, plan_min, plan_max, lo, hi);
    span = hi - lo;
    w = plan_width;
    if (w == 0) w = 1;
    repeat (n) begin
      if ($urandom_range(0, 9) < 4) begin
        if ($urandom_range(0, 3) == 0) begin
          push_read(POS_W'($urandom), $urandom_range(0, 99) == 0);
        end else begin
          r = $urandom_range(0, 32'(span) + 16);
          if (r > BIN_CAPACITY - 1) r = BIN_CAPACITY - 1;
          push_read(POS_W'(r));
        end
      end else if ($urandom_range(0, 9) == 0) begin
        push_add($urandom, $urandom_range(0, 99) == 0);
      end else begin
        reach = ($urandom_range(0, 15) == 0) ? 1100 : 24;
        b = $urandom_range(0, 32'(span) + 2 * reach);
        b = lo + b - reach;
        r = $urandom_range(0, 32'(w - 1));
        s = b * w + r;
        if (s > S_MAX) s = S_MAX;
        if (s < S_MIN) s = S_MIN;
        push_add(DATA_W'(s));
      end
    end
  endfunction

  // ---- driver ----
  always @(posedge clk) begin
    job_t head;
    logic go_in;
    logic go_cfg;
    go_in  = in_valid;
    go_cfg = cfg_valid;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        awaited_bins = {awaited_bins,
                        histogram_step(command_e'(command), sample, read_index)};
        items_in <= items_in + 1;
        go_in = 1'b0;
        if (!calm && $urandom_range(0, 3) == 0) hold = $urandom_range(1, 8);
      end
      if (cfg_valid && cfg_ready) begin
        write_reg(cfg_index, cfg_data);
        go_cfg = 1'b0;
      end
      if (!go_in && !go_cfg && jobs.size() != 0) begin
        if (hold != 0) begin
          hold = hold - 1;
          // bursts now and then run back to back
          if (hold == 0 && !calm && $urandom_range(0, 2) == 0) hold = $urandom_range(1, 8);
        end else if (!jobs[0].drain || (!in_valid && items_in == results_out)) begin
          head = jobs.pop_front();
          if (head.is_cfg) begin
            cfg_index <= head.idx;
            cfg_data  <= head.data;
            go_cfg = 1'b1;
          end else begin
            command    <= head.cmd;
            sample     <= head.smp;
            read_index <= head.ridx;
            go_in = 1'b1;
          end
        end
      end
      calm <= (jobs.size() < 120);
    end
    in_valid  <= go_in;
    cfg_valid <= go_cfg;
  end

  // ---- monitor ----
  always @(posedge clk) begin
    bin_result_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (results_out == items_in) begin
          $display("%0t: result expected none, got bin_position %0d bin_count %0d",
                   $time, bin_position, bin_count);
          mismatches++;
        end else begin
          want = awaited_bins.pop_front();
          results_out <= results_out + 1;
          check_field("bin_position", want.pos, bin_position);
          check_field("bin_count", want.count, bin_count);
          check_field("total_entries", want.total, total_entries);
          check_field("window_bins", want.wbins, window_bins);
          check_field("extension", want.ext, extension);
          check_field("rejected", want.rej, rejected);
        end
      end
      if (stall_left == 0 && !calm && $urandom_range(0, 11) == 0)
        stall_left = $urandom_range(1, 8);
      out_stall <= (stall_left != 0);
      if (stall_left != 0) stall_left = stall_left - 1;
    end
  end

  // ---- stimulus and end of run ----
  initial begin
    logic [DATA_W-1:0] mn;
    logic [WIDTH_W-1:0] w;
    reg_width  = RST_BIN_WIDTH;
    reg_min    = RST_RANGE_MIN;
    reg_max    = RST_RANGE_MAX;
    reframe();
    plan_width = RST_BIN_WIDTH;
    plan_min   = RST_RANGE_MIN;
    plan_max   = RST_RANGE_MAX;

    // reset window: bins 0..255 of width 1.0
    push_read(0);
    push_read(255);
    push_read(256);
    push_read(1023);
    push_add(0);
    push_add(32'h0000_FFFF);
    push_add(255 * 65536 + 65535);
    push_add(256 * 65536);          // one bin above
    push_add(-1);                   // floors to bin -1, below
    push_add(-65536);
    push_add(-65537);               // floors to bin -2
    push_add(1023 * 65536);         // would pass capacity
    push_add(32'h7FFF_FFFF);
    push_add(32'h8000_0000);
    push_add(1020 * 65536);         // long extension, clears most of the store
    push_read(1022);
    push_read(1023);
    push_add(-3 * 65536);           // window now exactly full
    push_add(-4 * 65536);
    push_read(1023, 1'b1);
    push_read(0);
    push_random(230);

    // zero width behaves as one
    push_reg(REG_BIN_WIDTH, 0);
    push_reg(REG_RANGE_MIN, -5);
    push_reg(REG_RANGE_MAX, 5);
    push_random(230);

    // widest bins over the full sample range
    push_reg(REG_BIN_WIDTH, 32'h7FFF_FFFF);
    push_reg(REG_RANGE_MIN, 32'h8000_0000);
    push_reg(REG_RANGE_MAX, 32'h7FFF_FFFF);
    push_random(200);

    // narrowest bins over the full range: window clipped to capacity
    push_reg(REG_BIN_WIDTH, 1);
    push_random(230);

    // inverted range collapses to one bin; unused index is a no-op
    push_reg(REG_BIN_WIDTH, 100);
    push_reg(REG_RANGE_MIN, 5000);
    push_reg(REG_RANGE_MAX, -5000);
    push_reg(REG_UNUSED, $urandom);
    push_random(230);

    repeat (3) begin
      w  = WIDTH_W'($urandom_range(1, 32'h7FFF_FFFF) >> $urandom_range(0, 30));
      mn = $urandom;
      push_reg(REG_BIN_WIDTH, DATA_W'(w));
      push_reg(REG_RANGE_MIN, mn);
      push_reg(REG_RANGE_MAX, mn + DATA_W'(w) * $urandom_range(0, 700));
      push_random(270);
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    forever begin
      @(posedge clk);
      #1;
      if (jobs.size() == 0 && !in_valid && !cfg_valid && items_in == results_out) break;
    end
    repeat (64) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_auto_ranging_histogram: done, clean");
    end else begin
      $display("tb_auto_ranging_histogram: done, errors");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("tb_auto_ranging_histogram: done, errors");
    $finish;
  end

endmodule
`default_nettype wire
